// File: sv/spi_eeprom_command_sequencer_defines.svh
// Assertion macros shared by the sequencer RTL.
`ifndef SPI_EEPROM_COMMAND_SEQUENCER_DEFINES_SVH
`define SPI_EEPROM_COMMAND_SEQUENCER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SEQ_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SEQ_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/spieecs_pkg.sv
package spieecs_pkg;

	localparam int PAGE_BYTES = 32;
	localparam int OFFSET_W   = $clog2(PAGE_BYTES);
	localparam int STEP_W     = 4;

	localparam logic [2:0] OP_READ    = 3'd0;
	localparam logic [2:0] OP_WRITE   = 3'd1;
	localparam logic [2:0] OP_WREN    = 3'd2;
	localparam logic [2:0] OP_WRDI    = 3'd3;
	localparam logic [2:0] OP_BURST   = 3'd4;

	localparam logic [7:0] CMD_READ  = 8'h03;
	localparam logic [7:0] CMD_WRITE = 8'h02;
	localparam logic [7:0] CMD_WREN  = 8'h06;
	localparam logic [7:0] CMD_WRDI  = 8'h04;

	// Step numbers inside the sequence tables (burst and single write share the write table).
	localparam logic [STEP_W-1:0] WR_REOPEN_FIRST = 4'd0;
	localparam logic [STEP_W-1:0] WR_SINGLE_FIRST = 4'd2;
	localparam logic [STEP_W-1:0] WR_DATA_STEP    = 4'd9;
	localparam logic [STEP_W-1:0] WR_CLOSE_LAST   = 4'd11;
	localparam logic [STEP_W-1:0] RD_LAST_STEP    = 4'd5;
	localparam logic [STEP_W-1:0] EN_LAST_STEP    = 4'd3;

	typedef enum logic [1:0] {
		ACT_SEND     = 2'd0,
		ACT_DEASSERT = 2'd1,
		ACT_ASSERT   = 2'd2,
		ACT_WAIT     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		SEQ_READ   = 2'd0,
		SEQ_ENABLE = 2'd1,
		SEQ_WRITE  = 2'd2
	} seq_kind_t;

	typedef struct packed {
		action_t    action;
		logic [7:0] tx_byte;
		logic       capture;
	} spi_act_t;

	// Action at one step of a sequence.
	function automatic spi_act_t step_action(
		input seq_kind_t         kind,
		input logic [7:0]        cmd,
		input logic [STEP_W-1:0] step,
		input logic [15:0]       addr,
		input logic [7:0]        data
	);
		spi_act_t a;
		a = '{action: ACT_SEND, tx_byte: 8'h00, capture: 1'b0};
		case (kind)
			SEQ_READ: begin
				case (step)
					4'd0: a.action = ACT_ASSERT;
					4'd1: a.tx_byte = CMD_READ;
					4'd2: a.tx_byte = addr[15:8];
					4'd3: a.tx_byte = addr[7:0];
					4'd4: a.capture = 1'b1;
					default: a.action = ACT_DEASSERT;
				endcase
			end
			SEQ_ENABLE: begin
				case (step)
					4'd0: a.action = ACT_ASSERT;
					4'd1: a.tx_byte = cmd;
					4'd2: a.action = ACT_DEASSERT;
					default: a.action = ACT_ASSERT;
				endcase
			end
			default: begin
				case (step)
					4'd0: a.action = ACT_DEASSERT;
					4'd1: a.action = ACT_WAIT;
					4'd2: a.action = ACT_ASSERT;
					4'd3: a.tx_byte = CMD_WREN;
					4'd4: a.action = ACT_DEASSERT;
					4'd5: a.action = ACT_ASSERT;
					4'd6: a.tx_byte = CMD_WRITE;
					4'd7: a.tx_byte = addr[15:8];
					4'd8: a.tx_byte = addr[7:0];
					4'd9: a.tx_byte = data;
					4'd10: a.action = ACT_DEASSERT;
					default: a.action = ACT_WAIT;
				endcase
			end
		endcase
		return a;
	endfunction

endpackage

// File: sv/spi_eeprom_command_sequencer.sv
// SPI EEPROM command sequencer (25xx-style parts).
// Input channel (in_valid/in_ready): one EEPROM request per item: opcode,
// address, data_byte and the burst first/last flags.
// Output channel (out_valid/out_ready): one SPI master action per item:
// send byte, deassert CS, assert CS or write-cycle wait; capture marks the
// dummy read byte and last marks the final action of a request.
// A request is registered on accept and expanded one action per cycle from
// a step counter into an output register while the receiver does not stall.
// The first action reaches the output through that register. A request
// yields 4 (enable), 6 (read), 10 (single write) or 1 to 12 (burst byte)
// actions, one per cycle unless stalled; the step counter sets the rate,
// and the next request is taken in the same cycle the last action of the
// current one moves to the output register.
// Undefined opcodes are accepted and dropped with no actions.
// Reset clears the request and output valid flags and the burst offset.
// When the receiver stalls, the output register holds its action and the
// step counter holds; the input side stalls once the request stage is full.
`include "spi_eeprom_command_sequencer_defines.svh"

module spi_eeprom_command_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  opcode,
	input  logic [15:0] address,
	input  logic [7:0]  data_byte,
	input  logic        first_of_burst,
	input  logic        last_of_burst,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  action,
	output logic [7:0]  tx_byte,
	output logic        capture,
	output logic        last
);
	import spieecs_pkg::*;

	// Request stage
	logic              req_valid_s1;
	seq_kind_t         kind_s1;
	logic [7:0]        cmd_s1;
	logic [15:0]       addr_s1;
	logic [7:0]        data_s1;
	logic [STEP_W-1:0] end_s1;
	logic [STEP_W-1:0] step_q;

	// Burst page offset from burst start
	logic [OFFSET_W-1:0] burst_offset_q;

	// Output register
	logic       out_valid_q;
	spi_act_t   out_act_q;
	logic       out_last_q;

	logic              in_accept;
	logic              op_known;
	logic              out_load;
	logic              step_is_last;
	logic              reopen;
	logic [OFFSET_W-1:0] offset_eff;
	seq_kind_t         kind_d;
	logic [7:0]        cmd_d;
	logic [STEP_W-1:0] start_d;
	logic [STEP_W-1:0] end_d;
	spi_act_t          act_d;

	assign op_known     = (opcode == OP_READ) || (opcode == OP_WRITE) || (opcode == OP_WREN)
		|| (opcode == OP_WRDI) || (opcode == OP_BURST);
	// Move an action forward when the output register is empty or draining.
	assign out_load     = req_valid_s1 && (!out_valid_q || out_ready);
	assign step_is_last = (step_q == end_s1);
	// Take a new request when the stage is empty or its last action leaves now.
	assign in_ready     = !req_valid_s1 || (out_load && step_is_last);
	assign in_accept    = in_valid && in_ready;

	// A first flag restarts the page count; offset zero reopens the write.
	assign offset_eff = first_of_burst ? '0 : burst_offset_q;
	assign reopen     = (offset_eff == '0);

	// Decode the request into a sequence and its step range.
	always_comb begin
		kind_d  = SEQ_WRITE;
		cmd_d   = CMD_WREN;
		start_d = WR_SINGLE_FIRST;
		end_d   = WR_CLOSE_LAST;
		case (opcode)
			OP_READ: begin
				kind_d  = SEQ_READ;
				start_d = '0;
				end_d   = RD_LAST_STEP;
			end
			OP_WREN: begin
				kind_d  = SEQ_ENABLE;
				start_d = '0;
				end_d   = EN_LAST_STEP;
			end
			OP_WRDI: begin
				kind_d  = SEQ_ENABLE;
				cmd_d   = CMD_WRDI;
				start_d = '0;
				end_d   = EN_LAST_STEP;
			end
			OP_BURST: begin
				start_d = reopen ? WR_REOPEN_FIRST : WR_DATA_STEP;
				end_d   = last_of_burst ? WR_CLOSE_LAST : WR_DATA_STEP;
			end
			default: begin
				kind_d = SEQ_WRITE;
			end
		endcase
	end

	// Hold the burst offset across requests; only burst bytes move it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_offset_q <= '0;
		end else if (in_accept && (opcode == OP_BURST)) begin
			if (last_of_burst || (offset_eff == OFFSET_W'(PAGE_BYTES - 1))) begin
				burst_offset_q <= '0;
			end else begin
				burst_offset_q <= offset_eff + 1'b1;
			end
		end
	end

	// Request stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
			step_q       <= '0;
		end else if (in_accept) begin
			// Drop undefined opcodes: no actions at all.
			req_valid_s1 <= op_known;
			step_q       <= start_d;
		end else if (out_load) begin
			if (step_is_last) begin
				req_valid_s1 <= 1'b0;
			end else begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// Request payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			kind_s1 <= kind_d;
			cmd_s1  <= cmd_d;
			addr_s1 <= address;
			data_s1 <= data_byte;
			end_s1  <= end_d;
		end
	end

	assign act_d = step_action(kind_s1, cmd_s1, step_q, addr_s1, data_s1);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_act_q  <= act_d;
			out_last_q <= step_is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign action    = out_act_q.action;
	assign tx_byte   = out_act_q.tx_byte;
	assign capture   = out_act_q.capture;
	assign last      = out_last_q;

	`SEQ_ASSERT_IMPL(a_step_in_range, req_valid_s1, step_q <= end_s1, "step past end of sequence")
	`SEQ_ASSERT_IMPL(a_offset_in_page, 1'b1, burst_offset_q <= OFFSET_W'(PAGE_BYTES - 1),
		"burst offset beyond page")
	`SEQ_ASSERT_IMPL(a_no_take_while_busy, req_valid_s1 && !out_load, !in_ready,
		"new request taken while stage busy")
	`SEQ_ASSERT_NEXT(a_known_op_starts, in_accept && op_known, req_valid_s1,
		"accepted request not started")

endmodule
